// ----- src/assert_macros.svh -----
// Assertion macros for the RTL of the merge sort engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- src/msort_pkg.sv -----
// Package with the types and constants of the merge sort engine.
`timescale 1ns / 1ps

package msort_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_res;
    } out_item_t;

    // Buffer access and status from the merge sequencer.
    typedef struct packed {
        logic              src_b;
        logic [ADDR_W-1:0] rd_addr0;
        logic [ADDR_W-1:0] rd_addr1;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              done;
    } merge_port_t;

endpackage

// ----- src/msort_ram.sv -----
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module msort_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr0,
    input  logic [ADDR_W-1:0] raddr1,
    output logic [DATA_W-1:0] rdata0,
    output logic [DATA_W-1:0] rdata1
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd0_reg;
    logic [DATA_W-1:0] rd1_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd0_reg <= mem[raddr0];
        rd1_reg <= mem[raddr1];
    end

    assign rdata0 = rd0_reg;
    assign rdata1 = rd1_reg;

endmodule

// ----- src/msort_merge.sv -----
// Bottom-up merge sequencer with one shared compare unit, one element per cycle in M_MERGE.
`timescale 1ns / 1ps

module msort_merge (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [msort_pkg::CNT_W-1:0]  count,
    input  logic [msort_pkg::DATA_W-1:0] a_rdata0,
    input  logic [msort_pkg::DATA_W-1:0] a_rdata1,
    input  logic [msort_pkg::DATA_W-1:0] b_rdata0,
    input  logic [msort_pkg::DATA_W-1:0] b_rdata1,
    output msort_pkg::merge_port_t       port
);

    localparam int CW = msort_pkg::CNT_W;
    localparam int AW = msort_pkg::ADDR_W;

    localparam logic [1:0] M_IDLE  = 2'd0;
    localparam logic [1:0] M_PRIME = 2'd1;
    localparam logic [1:0] M_MERGE = 2'd2;
    localparam logic [1:0] M_DONE  = 2'd3;

    // End of a run starting at lo with length len, clipped to n.
    function automatic logic [CW-1:0] run_bound(input logic [CW-1:0] lo,
                                                input logic [CW:0]   len,
                                                input logic [CW-1:0] n);
        logic [CW:0] sum;
        sum = {1'b0, lo} + len;
        if (sum > {1'b0, n}) begin
            return n;
        end
        return sum[CW-1:0];
    endfunction

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] w_reg, w_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic          src_b_reg, src_b_next;

    logic [msort_pkg::DATA_W-1:0] head_l, head_r;
    logic                         take_left;
    logic [CW-1:0]                k_inc, w_dbl, mid_new;
    logic                         run_end, pass_end;
    logic [AW-1:0]                rd_addr0, rd_addr1;
    logic                         wr_en;

    assign head_l    = src_b_reg ? b_rdata0 : a_rdata0;
    assign head_r    = src_b_reg ? b_rdata1 : a_rdata1;
    // Equal heads take the left run to keep input order.
    assign take_left = (i_reg < mid_reg) &&
                       ((j_reg >= hi_reg) || ($signed(head_l) <= $signed(head_r)));
    assign k_inc     = k_reg + CW'(1);
    assign run_end   = (k_inc == hi_reg);
    assign pass_end  = run_end && (hi_reg == n_reg);
    assign w_dbl     = {w_reg[CW-2:0], 1'b0};
    assign mid_new   = run_bound(hi_reg, {1'b0, w_reg}, n_reg);

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        w_next     = w_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        src_b_next = src_b_reg;
        wr_en      = 1'b0;
        rd_addr0   = i_reg[AW-1:0];
        rd_addr1   = j_reg[AW-1:0];
        case (state_reg)
            M_IDLE: begin
                if (start) begin
                    n_next     = count;
                    src_b_next = 1'b0;
                    if (count <= CW'(1)) begin
                        state_next = M_DONE;
                    end else begin
                        w_next     = CW'(1);
                        mid_next   = run_bound('0, (CW+1)'(1), count);
                        hi_next    = run_bound('0, (CW+1)'(2), count);
                        i_next     = '0;
                        j_next     = run_bound('0, (CW+1)'(1), count);
                        k_next     = '0;
                        state_next = M_PRIME;
                    end
                end
            end
            M_PRIME: begin
                // present read addresses i and j so that the heads arrive for M_MERGE
                state_next = M_MERGE;
            end
            M_MERGE: begin
                wr_en  = 1'b1;
                k_next = k_inc;
                if (take_left) begin
                    i_next = i_reg + CW'(1);
                end else begin
                    j_next = j_reg + CW'(1);
                end
                if (pass_end) begin
                    src_b_next = !src_b_reg;
                    if (w_dbl >= n_reg) begin
                        state_next = M_DONE;
                    end else begin
                        w_next     = w_dbl;
                        mid_next   = run_bound('0, {1'b0, w_dbl}, n_reg);
                        hi_next    = run_bound('0, {w_dbl, 1'b0}, n_reg);
                        i_next     = '0;
                        j_next     = run_bound('0, {1'b0, w_dbl}, n_reg);
                        k_next     = '0;
                        state_next = M_PRIME;
                    end
                end else if (run_end) begin
                    // start the next run pair without a bubble
                    mid_next = mid_new;
                    hi_next  = run_bound(hi_reg, {w_reg, 1'b0}, n_reg);
                    i_next   = hi_reg;
                    j_next   = mid_new;
                    k_next   = hi_reg;
                    rd_addr0 = hi_reg[AW-1:0];
                    rd_addr1 = mid_new[AW-1:0];
                end else begin
                    rd_addr0 = i_next[AW-1:0];
                    rd_addr1 = j_next[AW-1:0];
                end
            end
            M_DONE: begin
                state_next = M_IDLE;
            end
            default: begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            src_b_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            src_b_reg <= src_b_next;
        end
        n_reg   <= n_next;
        w_reg   <= w_next;
        mid_reg <= mid_next;
        hi_reg  <= hi_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
    end

    always_comb begin
        port.src_b    = src_b_reg;
        port.rd_addr0 = rd_addr0;
        port.rd_addr1 = rd_addr1;
        port.wr_en    = wr_en;
        port.wr_addr  = k_reg[AW-1:0];
        port.wr_data  = take_left ? head_l : head_r;
        port.done     = (state_reg == M_DONE);
    end

endmodule

// ----- src/merge_sort_engine.sv -----
// Loading: accepted items are written into buffer A; the last item starts the sort.
// Sort: bottom-up merge passes between the two buffers, one element per cycle
// through the shared compare unit apart from a priming state before each pass;
// then each result is read, then held until m_ready. One set at a time.
// Reset: aresetn, synchronous active low, clears the element count and control;
// the two buffers are not cleared and only entries of the current set are read.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module merge_sort_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  msort_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output msort_pkg::out_item_t m_item
);

    localparam int CW = msort_pkg::CNT_W;
    localparam int AW = msort_pkg::ADDR_W;
    localparam int DW = msort_pkg::DATA_W;

    localparam logic [1:0] T_LOAD = 2'd0;
    localparam logic [1:0] T_SORT = 2'd1;
    localparam logic [1:0] T_RD   = 2'd2;
    localparam logic [1:0] T_OUT  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          sel_b_reg, sel_b_next;

    logic          accept, room, load_we, last_idx;
    logic [CW-1:0] count_inc;
    logic [AW-1:0] raddr0;

    logic          a_we, b_we;
    logic [AW-1:0] a_waddr;
    logic [DW-1:0] a_wdata;
    logic [DW-1:0] a_rdata0, a_rdata1, b_rdata0, b_rdata1;

    msort_pkg::merge_port_t mp;

    assign s_ready   = (state_reg == T_LOAD);
    assign accept    = s_valid && s_ready;
    assign room      = (count_reg < CW'(msort_pkg::DEPTH));
    assign load_we   = accept && room;
    assign count_inc = count_reg + CW'(room);
    assign last_idx  = ({1'b0, idx_reg} + CW'(1)) == count_reg;
    assign raddr0    = (state_reg == T_SORT) ? mp.rd_addr0 : idx_reg;

    // Buffer A takes loads and merge writes when B is the source.
    assign a_we    = load_we || (mp.wr_en && mp.src_b);
    assign a_waddr = load_we ? count_reg[AW-1:0] : mp.wr_addr;
    assign a_wdata = load_we ? DW'(s_item.value) : mp.wr_data;
    assign b_we    = mp.wr_en && !mp.src_b;

    msort_ram #(.ADDR_W(AW), .DATA_W(DW)) u_buf_a (
        .aclk   (aclk),
        .we     (a_we),
        .waddr  (a_waddr),
        .wdata  (a_wdata),
        .raddr0 (raddr0),
        .raddr1 (mp.rd_addr1),
        .rdata0 (a_rdata0),
        .rdata1 (a_rdata1)
    );

    msort_ram #(.ADDR_W(AW), .DATA_W(DW)) u_buf_b (
        .aclk   (aclk),
        .we     (b_we),
        .waddr  (mp.wr_addr),
        .wdata  (mp.wr_data),
        .raddr0 (raddr0),
        .raddr1 (mp.rd_addr1),
        .rdata0 (b_rdata0),
        .rdata1 (b_rdata1)
    );

    msort_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept && s_item.last),
        .count    (count_inc),
        .a_rdata0 (a_rdata0),
        .a_rdata1 (a_rdata1),
        .b_rdata0 (b_rdata0),
        .b_rdata1 (b_rdata1),
        .port     (mp)
    );

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        sel_b_next = sel_b_reg;
        case (state_reg)
            T_LOAD: begin
                if (accept) begin
                    count_next = count_inc;
                    if (s_item.last) begin
                        state_next = T_SORT;
                    end
                end
            end
            T_SORT: begin
                if (mp.done) begin
                    sel_b_next = mp.src_b;
                    idx_next   = '0;
                    state_next = T_RD;
                end
            end
            T_RD: begin
                state_next = T_OUT;
            end
            T_OUT: begin
                if (m_ready) begin
                    if (last_idx) begin
                        count_next = '0;
                        state_next = T_LOAD;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = T_RD;
                    end
                end
            end
            default: begin
                state_next = T_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_LOAD;
            count_reg <= '0;
            idx_reg   <= '0;
            sel_b_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            sel_b_reg <= sel_b_next;
        end
    end

    assign m_valid             = (state_reg == T_OUT);
    assign m_item.sorted_value = sel_b_reg ? b_rdata0 : a_rdata0;
    assign m_item.final_res    = last_idx;

    `ASSERT_IMP(a_no_overlap, aclk, aresetn, s_ready, !m_valid)
    `ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(msort_pkg::DEPTH))
    `ASSERT_IMP(a_done_in_sort, aclk, aresetn, mp.done, state_reg == T_SORT)
    `ASSERT_NEXT(a_back_to_load, aclk, aresetn, m_valid && m_ready && m_item.final_res, s_ready && count_reg == '0)

endmodule
